>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define NPPOC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nppoc assertion failed");

// default clock and reset names
`define NPPOC_ASSERT(label, prop) \
  `NPPOC_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

>>> sv/nppoc_pkg.sv
// ----------------------------------------------------------------------------
// nppoc_pkg
// shared constants and types of the page program order checker
// ----------------------------------------------------------------------------
package nppoc_pkg;

  // default geometry limits
  localparam int DefMaxChannels = 4;
  localparam int DefMaxLuns     = 4;
  localparam int DefMaxPlanes   = 2;
  localparam int DefMaxBlocks   = 256;
  localparam int DefMaxPages    = 64;

  // field widths
  localparam int OpW      = 2;
  localparam int ChW      = 2;
  localparam int LunW     = 2;
  localparam int PlaneW   = 1;
  localparam int BlockW   = 8;
  localparam int PageW    = 6;
  localparam int StatusW  = 2;
  localparam int LastOffW = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  // operations
  localparam logic [OpW-1:0] OpProgram    = 2'd0;
  localparam logic [OpW-1:0] OpErase      = 2'd1;
  localparam logic [OpW-1:0] OpQueryPage  = 2'd2;
  localparam logic [OpW-1:0] OpQueryBlock = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StRange    = 2'd1;
  localparam logic [StatusW-1:0] StNotFree  = 2'd2;
  localparam logic [StatusW-1:0] StOrder    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgChannels = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLuns     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPlanes   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlocks   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPages    = 3'd4;

  // last offset of a block with no programmed page
  localparam logic [LastOffW-1:0] LastNone = 7'h7f;

  typedef struct packed {
    logic clear_we;
    logic accept;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

>>> sv/nppoc_dp.sv
// ----------------------------------------------------------------------------
// nppoc_dp
// datapath: size registers, range check, block state memory, result registers
// ----------------------------------------------------------------------------
module nppoc_dp #(
  parameter int MAX_CHANNELS = nppoc_pkg::DefMaxChannels,
  parameter int MAX_LUNS     = nppoc_pkg::DefMaxLuns,
  parameter int MAX_PLANES   = nppoc_pkg::DefMaxPlanes,
  parameter int MAX_BLOCKS   = nppoc_pkg::DefMaxBlocks,
  parameter int MAX_PAGES    = nppoc_pkg::DefMaxPages
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  nppoc_pkg::dp_cmd_t                    cmd_i,
  output nppoc_pkg::dp_stat_t                   stat_o,
  input  logic                                  cfg_we_i,
  input  logic [nppoc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [nppoc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic [nppoc_pkg::OpW-1:0]             operation_i,
  input  logic [nppoc_pkg::ChW-1:0]             channel_i,
  input  logic [nppoc_pkg::LunW-1:0]            lun_i,
  input  logic [nppoc_pkg::PlaneW-1:0]          plane_i,
  input  logic [nppoc_pkg::BlockW-1:0]          block_i,
  input  logic [nppoc_pkg::PageW-1:0]           page_i,
  output logic [nppoc_pkg::StatusW-1:0]         status_o,
  output logic                                  page_used_o,
  output logic signed [nppoc_pkg::LastOffW-1:0] last_offset_o
);

  localparam int Depth = MAX_CHANNELS * MAX_LUNS * MAX_PLANES * MAX_BLOCKS;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int OffW  = nppoc_pkg::LastOffW;
  localparam int MemW  = MAX_PAGES + OffW;

  // size registers
  logic [2:0] cfg_ch_q, cfg_lun_q;
  logic [1:0] cfg_pl_q;
  logic [8:0] cfg_blk_q;
  logic [6:0] cfg_pg_q;

  // captured command
  logic [nppoc_pkg::OpW-1:0]   op_q;
  logic [nppoc_pkg::PageW-1:0] pg_q;
  logic [IdxW-1:0]             idx_q;
  logic                        ok_q;
  logic [MemW-1:0]             rd_q;

  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;

  logic [MemW-1:0] mem [Depth];

  logic [nppoc_pkg::StatusW-1:0] status_q, status_d;
  logic                          used_q, used_d;
  logic [OffW-1:0]               last_q, last_d;

  logic        page_cmd, in_ok;
  logic [31:0] idx_full;
  logic [IdxW-1:0] rd_idx;

  logic [MAX_PAGES-1:0] used_w, mask_w;
  logic [OffW-1:0]      last_w;
  logic                 hit_w;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [MemW-1:0]      mem_wdata;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ch_q  <= 3'd4;
      cfg_lun_q <= 3'd4;
      cfg_pl_q  <= 2'd2;
      cfg_blk_q <= 9'd256;
      cfg_pg_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nppoc_pkg::CfgChannels: cfg_ch_q  <= cfg_wdata_i[2:0];
        nppoc_pkg::CfgLuns:     cfg_lun_q <= cfg_wdata_i[2:0];
        nppoc_pkg::CfgPlanes:   cfg_pl_q  <= cfg_wdata_i[1:0];
        nppoc_pkg::CfgBlocks:   cfg_blk_q <= cfg_wdata_i;
        nppoc_pkg::CfgPages:    cfg_pg_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // range check and block index
  assign page_cmd = (operation_i == nppoc_pkg::OpProgram) ||
                    (operation_i == nppoc_pkg::OpQueryPage);

  assign in_ok = (3'(channel_i) < cfg_ch_q) && (32'(channel_i) < 32'(MAX_CHANNELS)) &&
                 (3'(lun_i) < cfg_lun_q) && (32'(lun_i) < 32'(MAX_LUNS)) &&
                 (2'(plane_i) < cfg_pl_q) && (32'(plane_i) < 32'(MAX_PLANES)) &&
                 (9'(block_i) < cfg_blk_q) && (32'(block_i) < 32'(MAX_BLOCKS)) &&
                 (!page_cmd ||
                  ((7'(page_i) < cfg_pg_q) && (32'(page_i) < 32'(MAX_PAGES))));

  assign idx_full = ((32'(channel_i) * 32'(MAX_LUNS) + 32'(lun_i)) * 32'(MAX_PLANES)
                     + 32'(plane_i)) * 32'(MAX_BLOCKS) + 32'(block_i);
  assign rd_idx   = idx_full[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= operation_i;
      pg_q  <= page_i;
      idx_q <= rd_idx;
      ok_q  <= in_ok;
    end
  end

  // clear sweep counter
  assign clr_cnt_d = clr_cnt_q + IdxW'(1);
  assign stat_o.clear_done = (clr_cnt_q == IdxW'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_we) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // execute
  assign used_w = rd_q[MemW-1:OffW];
  assign last_w = rd_q[OffW-1:0];
  assign hit_w  = used_w[0] & 1'b0 | ((used_w >> pg_q) & MAX_PAGES'(1)) != '0;
  assign mask_w = MAX_PAGES'(1) << pg_q;

  always_comb begin
    status_d  = nppoc_pkg::StOk;
    used_d    = 1'b0;
    last_d    = '0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {used_w | mask_w, OffW'(pg_q)};
    if (cmd_i.clear_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = {MAX_PAGES'(0), nppoc_pkg::LastNone};
    end else if (!ok_q) begin
      status_d = nppoc_pkg::StRange;
    end else begin
      case (op_q)
        nppoc_pkg::OpProgram: begin
          if (hit_w) begin
            status_d = nppoc_pkg::StNotFree;
          end else if (last_w != (OffW'(pg_q) - OffW'(1))) begin
            status_d = nppoc_pkg::StOrder;
          end else begin
            mem_we = cmd_i.exec;
          end
        end
        nppoc_pkg::OpErase: begin
          mem_we    = cmd_i.exec;
          mem_wdata = {MAX_PAGES'(0), nppoc_pkg::LastNone};
        end
        nppoc_pkg::OpQueryPage: begin
          used_d = hit_w;
        end
        default: begin
          last_d = last_w;
        end
      endcase
    end
  end

  // block state memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[rd_idx];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      used_q   <= used_d;
      last_q   <= last_d;
    end
  end

  assign status_o      = status_q;
  assign page_used_o   = used_q;
  assign last_offset_o = $signed(last_q);

endmodule

>>> sv/nppoc_ctrl.sv
// ----------------------------------------------------------------------------
// nppoc_ctrl
// controller: clear sweep, item handshake, result valid
// ----------------------------------------------------------------------------
module nppoc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nppoc_pkg::dp_cmd_t  cmd_o,
  input  nppoc_pkg::dp_stat_t stat_i
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear_we = 1'b1;
        if (stat_i.clear_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = !out_valid_q || !out_stall_i;
        if (cmd_o.exec) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    out_valid_d = cmd_o.exec || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/nand_page_program_order_checker.sv
// ----------------------------------------------------------------------------
// nand_page_program_order_checker
// tracks programmed pages and last written offsets of nand erase blocks
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with operation and target address;
// an item is taken on a clock edge with valid high and stall low
// output channel: out_valid_o / out_stall_i with status, page_used and
// last_offset; exactly one result per item, in order
// each item is read, then executed: the block state entry is read from synchronous
// memory on the accept edge, then checked and written back when it leaves execute,
// which also loads the result register; one item is in flight at a time
// the result register lets the next item be taken while a result waits;
// a stalled result holds the item in execute, and the input stalls meanwhile
// after reset the state memory is swept once, one block per cycle, over all
// MAX_CHANNELS * MAX_LUNS * MAX_PLANES * MAX_BLOCKS blocks (8192 by default),
// with the input stalled; size registers may be written at any time the
// block is idle, also during the sweep
// ----------------------------------------------------------------------------
module nand_page_program_order_checker #(
  parameter int MAX_CHANNELS = nppoc_pkg::DefMaxChannels,
  parameter int MAX_LUNS     = nppoc_pkg::DefMaxLuns,
  parameter int MAX_PLANES   = nppoc_pkg::DefMaxPlanes,
  parameter int MAX_BLOCKS   = nppoc_pkg::DefMaxBlocks,
  parameter int MAX_PAGES    = nppoc_pkg::DefMaxPages
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nppoc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [nppoc_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [nppoc_pkg::OpW-1:0]             operation_i,
  input  logic [nppoc_pkg::ChW-1:0]             channel_i,
  input  logic [nppoc_pkg::LunW-1:0]            lun_i,
  input  logic [nppoc_pkg::PlaneW-1:0]          plane_i,
  input  logic [nppoc_pkg::BlockW-1:0]          block_i,
  input  logic [nppoc_pkg::PageW-1:0]           page_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [nppoc_pkg::StatusW-1:0]         status_o,
  output logic                                  page_used_o,
  output logic signed [nppoc_pkg::LastOffW-1:0] last_offset_o
);

  nppoc_pkg::dp_cmd_t  cmd;
  nppoc_pkg::dp_stat_t stat;

  nppoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  nppoc_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_LUNS     (MAX_LUNS),
    .MAX_PLANES   (MAX_PLANES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .MAX_PAGES    (MAX_PAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .channel_i     (channel_i),
    .lun_i         (lun_i),
    .plane_i       (plane_i),
    .block_i       (block_i),
    .page_i        (page_i),
    .status_o      (status_o),
    .page_used_o   (page_used_o),
    .last_offset_o (last_offset_o)
  );

endmodule

>>> sv/nppoc_checker.sv
// ----------------------------------------------------------------------------
// nppoc_checker
// port level assertions for the page program order checker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nppoc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [nppoc_pkg::StatusW-1:0]         status_o,
  input logic                                  page_used_o,
  input logic signed [nppoc_pkg::LastOffW-1:0] last_offset_o
);

  // a stalled result stays offered
  `NPPOC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // one item in flight: input stalls right after an accept
  `NPPOC_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o)

  // failing commands carry zero answer fields
  `NPPOC_ASSERT(a_fail_zero,
    out_valid_o && status_o != nppoc_pkg::StOk |-> !page_used_o && last_offset_o == '0)

  // a used page answer only comes from a successful page query
  `NPPOC_ASSERT(a_used_ok,
    out_valid_o && page_used_o |-> status_o == nppoc_pkg::StOk && last_offset_o == '0)

endmodule

bind nand_page_program_order_checker nppoc_checker u_nppoc_checker (.*);
